@@ design/iirl_pkg.sv @@
// ============================================================================
// iirl_pkg - shared definitions for the indexed insert/remove list
// Sizes, operation and status codes, and field types used by the interfaces,
// the top level and the bench.
// ============================================================================
package iirl_pkg;

    // List geometry
    localparam int DEPTH      = 16;
    localparam int WORD_WIDTH = 32;
    localparam int ADDR_W     = $clog2(DEPTH);
    localparam int CNT_W      = $clog2(DEPTH + 1);

    // Fixed transaction field widths
    localparam int MODE_W   = 3;
    localparam int POS_W    = 5;
    localparam int VALUE_W  = 32;
    localparam int COUNT_W  = 5;
    localparam int STATUS_W = 2;

    // Width used to compare a position against the entry count
    localparam int CMP_W = (POS_W > CNT_W) ? POS_W : CNT_W;

    typedef enum logic [MODE_W-1:0] {
        MODE_ADD_FRONT    = 3'd0,
        MODE_ADD_BACK     = 3'd1,
        MODE_INSERT_AT    = 3'd2,
        MODE_REMOVE_FRONT = 3'd3,
        MODE_REMOVE_BACK  = 3'd4,
        MODE_REMOVE_AT    = 3'd5,
        MODE_READ         = 3'd6,
        MODE_WRITE        = 3'd7
    } mode_t;

    typedef enum logic [STATUS_W-1:0] {
        ST_OK    = 2'd0,
        ST_EMPTY = 2'd1,
        ST_RANGE = 2'd2,
        ST_FULL  = 2'd3
    } status_t;

    typedef logic [WORD_WIDTH-1:0] word_t;
    typedef logic [ADDR_W-1:0]     addr_t;
    typedef logic [CNT_W-1:0]      cnt_t;
    typedef logic [POS_W-1:0]      pos_t;
    typedef logic [VALUE_W-1:0]    value_t;
    typedef logic [COUNT_W-1:0]    count_t;

endpackage

@@ design/iirl_req_if.sv @@
// ============================================================================
// iirl_req_if - request channel of the indexed insert/remove list
// Valid/ready channel carrying one list operation per transaction.
// ============================================================================
interface iirl_req_if;
    import iirl_pkg::*;

    logic   valid;
    logic   ready;
    mode_t  mode;
    pos_t   position;
    value_t value;

    modport source (output valid, output mode, output position, output value,
                    input ready);
    modport sink   (input valid, input mode, input position, input value,
                    output ready);
endinterface

@@ design/iirl_rsp_if.sv @@
// ============================================================================
// iirl_rsp_if - response channel of the indexed insert/remove list
// Valid/ready channel carrying one result per request transaction.
// ============================================================================
interface iirl_rsp_if;
    import iirl_pkg::*;

    logic    valid;
    logic    ready;
    value_t  read_value;
    count_t  count;
    status_t status;

    modport source (output valid, output read_value, output count, output status,
                    input ready);
    modport sink   (input valid, input read_value, input count, input status,
                    output ready);
endinterface

@@ design/iirl_ram.sv @@
// ============================================================================
// iirl_ram - generic simple dual-port RAM
// One write port and one read port, read data registered.
// ============================================================================
module iirl_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 16
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

@@ design/indexed_insert_remove_list_top.sv @@
// ============================================================================
// indexed_insert_remove_list_top - bounded ordered list of words
// Insert/remove at front, back or an index, read and overwrite an index.
// Entries live in a RAM; a small sequencer moves them one cell at a time.
// ============================================================================
//
//  channel | dir | handshake    | payload
//  --------+-----+--------------+----------------------------------
//  req     | in  | valid/ready  | mode, position, value
//  rsp     | out | valid/ready  | read_value, count, status
//
//  A failed op goes straight to the result step; an insert moves each entry
//  from position to the tail up one cell, then writes the new word; a remove
//  reads the word leaving, then moves each later entry down one cell. Each cell
//  move is one registered read then one write on the single RAM port pair.
//  Reset: asynchronous; clears the entry count and the sequencer, no RAM sweep.
//  Stalls: a new request is taken as soon as the sequencer is idle, even while
//  the previous result waits in the output register; rsp stall holds the next
//  result in its final step.
//
module indexed_insert_remove_list_top (
    input  logic clk,
    input  logic rst_n,
    iirl_req_if.sink   req,
    iirl_rsp_if.source rsp
);
    import iirl_pkg::*;

    typedef enum logic [3:0] {
        S_IDLE,
        S_UP_RD,
        S_UP_WR,
        S_RM_RD,
        S_RM_CAP,
        S_DN_RD,
        S_DN_WR,
        S_RD_RD,
        S_RD_CAP,
        S_WR_CELL,
        S_DONE
    } state_t;

    state_t  state_reg, state_next;
    addr_t   idx_reg, idx_next;
    addr_t   pos_reg, pos_next;
    word_t   word_reg, word_next;
    word_t   rv_reg, rv_next;
    status_t status_reg, status_next;
    cnt_t    cnt_reg, cnt_next;

    logic    out_valid_reg, out_valid_next;
    value_t  out_rv_reg, out_rv_next;
    count_t  out_cnt_reg, out_cnt_next;
    status_t out_status_reg, out_status_next;

    logic    ram_we;
    addr_t   ram_waddr;
    word_t   ram_wdata;
    addr_t   ram_raddr;
    word_t   ram_rdata;

    logic             full;
    logic             empty;
    logic [CMP_W-1:0] pos_ext;
    logic [CMP_W-1:0] cnt_ext;
    addr_t            target;
    logic             out_free;

    // Entry storage
    iirl_ram #(
        .WIDTH(WORD_WIDTH),
        .DEPTH(DEPTH)
    ) u_ram (
        .clk  (clk),
        .we   (ram_we),
        .waddr(ram_waddr),
        .wdata(ram_wdata),
        .raddr(ram_raddr),
        .rdata(ram_rdata)
    );

    // Request decode helpers
    assign full     = (cnt_reg >= CNT_W'(DEPTH));
    assign empty    = (cnt_reg == '0);
    assign pos_ext  = CMP_W'(req.position);
    assign cnt_ext  = CMP_W'(cnt_reg);
    assign out_free = !out_valid_reg || rsp.ready;

    assign req.ready = (state_reg == S_IDLE);

    // Sequencer next state, RAM control and result capture
    always_comb
    begin
        state_next      = state_reg;
        idx_next        = idx_reg;
        pos_next        = pos_reg;
        word_next       = word_reg;
        rv_next         = rv_reg;
        status_next     = status_reg;
        cnt_next        = cnt_reg;
        out_valid_next  = out_valid_reg && !rsp.ready;
        out_rv_next     = out_rv_reg;
        out_cnt_next    = out_cnt_reg;
        out_status_next = out_status_reg;
        ram_we          = 1'b0;
        ram_waddr       = idx_reg;
        ram_wdata       = ram_rdata;
        ram_raddr       = pos_reg;
        target          = '0;

        unique case (state_reg)
            S_IDLE:
            begin
                if (req.valid)
                begin
                    word_next   = word_t'(req.value);
                    rv_next     = '0;
                    status_next = ST_OK;
                    state_next  = S_DONE;
                    unique case (req.mode)
                        MODE_ADD_FRONT:
                        begin
                            target = '0;
                            if (full) status_next = ST_FULL;
                            else      state_next  = S_UP_RD;
                        end
                        MODE_ADD_BACK:
                        begin
                            target = ADDR_W'(cnt_reg);
                            if (full) status_next = ST_FULL;
                            else      state_next  = S_UP_RD;
                        end
                        MODE_INSERT_AT:
                        begin
                            target = ADDR_W'(req.position);
                            if (pos_ext > cnt_ext) status_next = ST_RANGE;
                            else if (full)         status_next = ST_FULL;
                            else                   state_next  = S_UP_RD;
                        end
                        MODE_REMOVE_FRONT:
                        begin
                            target = '0;
                            if (empty) status_next = ST_EMPTY;
                            else       state_next  = S_RM_RD;
                        end
                        MODE_REMOVE_BACK:
                        begin
                            target = ADDR_W'(cnt_reg - CNT_W'(1));
                            if (empty) status_next = ST_EMPTY;
                            else       state_next  = S_RM_RD;
                        end
                        MODE_REMOVE_AT:
                        begin
                            target = ADDR_W'(req.position);
                            if (empty)                  status_next = ST_EMPTY;
                            else if (pos_ext >= cnt_ext) status_next = ST_RANGE;
                            else                        state_next  = S_RM_RD;
                        end
                        MODE_READ:
                        begin
                            target = ADDR_W'(req.position);
                            if (empty)                  status_next = ST_EMPTY;
                            else if (pos_ext >= cnt_ext) status_next = ST_RANGE;
                            else                        state_next  = S_RD_RD;
                        end
                        MODE_WRITE:
                        begin
                            target = ADDR_W'(req.position);
                            if (empty)                  status_next = ST_EMPTY;
                            else if (pos_ext >= cnt_ext) status_next = ST_RANGE;
                            else                        state_next  = S_WR_CELL;
                        end
                        default:
                        begin
                            status_next = ST_OK;
                        end
                    endcase
                    pos_next = target;
                    // insert walks down from the current tail
                    idx_next = ADDR_W'(cnt_reg);
                end
            end

            // Shift up: move cell idx-1 into idx until the gap reaches pos
            S_UP_RD:
            begin
                if (idx_reg == pos_reg)
                begin
                    ram_we     = 1'b1;
                    ram_waddr  = pos_reg;
                    ram_wdata  = word_reg;
                    cnt_next   = cnt_reg + CNT_W'(1);
                    state_next = S_DONE;
                end
                else
                begin
                    ram_raddr  = idx_reg - ADDR_W'(1);
                    state_next = S_UP_WR;
                end
            end
            S_UP_WR:
            begin
                ram_we     = 1'b1;
                ram_waddr  = idx_reg;
                idx_next   = idx_reg - ADDR_W'(1);
                state_next = S_UP_RD;
            end

            // Remove: fetch the word leaving, then close the gap
            S_RM_RD:
            begin
                ram_raddr  = pos_reg;
                state_next = S_RM_CAP;
            end
            S_RM_CAP:
            begin
                rv_next    = ram_rdata;
                idx_next   = pos_reg;
                state_next = S_DN_RD;
            end
            S_DN_RD:
            begin
                if (CNT_W'(idx_reg) + CNT_W'(1) == cnt_reg)
                begin
                    cnt_next   = cnt_reg - CNT_W'(1);
                    state_next = S_DONE;
                end
                else
                begin
                    ram_raddr  = idx_reg + ADDR_W'(1);
                    state_next = S_DN_WR;
                end
            end
            S_DN_WR:
            begin
                ram_we     = 1'b1;
                ram_waddr  = idx_reg;
                idx_next   = idx_reg + ADDR_W'(1);
                state_next = S_DN_RD;
            end

            // Read one cell
            S_RD_RD:
            begin
                ram_raddr  = pos_reg;
                state_next = S_RD_CAP;
            end
            S_RD_CAP:
            begin
                rv_next    = ram_rdata;
                state_next = S_DONE;
            end

            // Overwrite one cell
            S_WR_CELL:
            begin
                ram_we     = 1'b1;
                ram_waddr  = pos_reg;
                ram_wdata  = word_reg;
                state_next = S_DONE;
            end

            // Hand the result to the output register once it is free
            S_DONE:
            begin
                if (out_free)
                begin
                    out_valid_next  = 1'b1;
                    out_rv_next     = VALUE_W'(rv_reg);
                    out_cnt_next    = COUNT_W'(cnt_reg);
                    out_status_next = status_reg;
                    state_next      = S_IDLE;
                end
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // State and registered outputs
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= S_IDLE;
            cnt_reg        <= '0;
            out_valid_reg  <= 1'b0;
            idx_reg        <= '0;
            pos_reg        <= '0;
            word_reg       <= '0;
            rv_reg         <= '0;
            status_reg     <= ST_OK;
            out_rv_reg     <= '0;
            out_cnt_reg    <= '0;
            out_status_reg <= ST_OK;
        end
        else
        begin
            state_reg      <= state_next;
            cnt_reg        <= cnt_next;
            out_valid_reg  <= out_valid_next;
            idx_reg        <= idx_next;
            pos_reg        <= pos_next;
            word_reg       <= word_next;
            rv_reg         <= rv_next;
            status_reg     <= status_next;
            out_rv_reg     <= out_rv_next;
            out_cnt_reg    <= out_cnt_next;
            out_status_reg <= out_status_next;
        end
    end

    assign rsp.valid      = out_valid_reg;
    assign rsp.read_value = out_rv_reg;
    assign rsp.count      = out_cnt_reg;
    assign rsp.status     = out_status_reg;

    // Checks on the sequencer
    a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
        cnt_reg <= CNT_W'(DEPTH))
        else $error("entry count above depth");

    a_cnt_change: assert property (@(posedge clk) disable iff (!rst_n)
        (cnt_reg != $past(cnt_reg)) |->
            ($past(state_reg) == S_UP_RD || $past(state_reg) == S_DN_RD))
        else $error("entry count changed outside a final shift step");

    a_write_in_list: assert property (@(posedge clk) disable iff (!rst_n)
        ram_we |-> (CNT_W'(ram_waddr) <= cnt_reg))
        else $error("RAM write beyond the list tail");

    a_fail_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && out_status_reg != ST_OK) |-> (out_rv_reg == '0))
        else $error("failed operation returned nonzero data");

endmodule

@@ bench/indexed_insert_remove_list_top_tb.sv @@
`timescale 1ns / 100ps
// ============================================================================
// indexed_insert_remove_list_top_tb - list operation bench
// Sends insert, remove, read and write operations through the request
// channel, mirrors the list contents in a scoreboard and checks the read
// word, entry count and status of every response against that mirror.
// Both channels idle at random.
// ============================================================================
module indexed_insert_remove_list_top_tb;
    import iirl_pkg::*;

    localparam int CLK_PERIOD = 8;
    localparam int RESET_CYCLES = 6;
    localparam int RANDOM_OPS = 1800;
    localparam int IDLE_LIMIT = 2000;
    // Longest sequencer run: a removal at the front of a full list
    localparam int DRAIN_CYCLES = 2 * DEPTH + 8;

    typedef struct packed {
        value_t  read_value;
        count_t  count;
        status_t status;
    } list_result_t;

    // ------------------------------------------------------------------------
    // Scoreboard: mirrored list contents plus the queue of pending responses
    // ------------------------------------------------------------------------
    class list_scoreboard;
        word_t shadow [DEPTH];
        int unsigned fill;
        list_result_t expected_q [$];
        int unsigned errors;

        function new();
            fill = 0;
            errors = 0;
        endfunction

        task report_mismatch(string what);
            if (errors < 100)
                $display("ERROR @%0t: %s", $time, what);
            errors++;
        endtask

        // Shift entries at or above pos up and place w at pos
        function void open_slot(int unsigned pos, value_t w);
            for (int unsigned i = fill; i > pos; i--)
                shadow[i] = shadow[i-1];
            shadow[pos] = w;
            fill++;
        endfunction

        // Take the entry at pos out and close the gap
        function value_t close_slot(int unsigned pos);
            value_t w;
            w = shadow[pos];
            for (int unsigned i = pos; i + 1 < fill; i++)
                shadow[i] = shadow[i+1];
            fill--;
            return w;
        endfunction

        function int unsigned pending();
            return expected_q.size();
        endfunction

        // Called on each accepted request transaction
        function void note_request(mode_t m, pos_t p, value_t v);
            list_result_t r;
            bit is_full;
            bit is_empty;
            r.read_value = '0;
            r.status = ST_OK;
            is_full = (fill >= DEPTH);
            is_empty = (fill == 0);
            case (m)
                MODE_ADD_FRONT:
                    if (is_full) r.status = ST_FULL;
                    else open_slot(0, v);
                MODE_ADD_BACK:
                    if (is_full) r.status = ST_FULL;
                    else open_slot(fill, v);
                MODE_INSERT_AT:
                    if (p > fill) r.status = ST_RANGE;
                    else if (is_full) r.status = ST_FULL;
                    else open_slot(p, v);
                MODE_REMOVE_FRONT:
                    if (is_empty) r.status = ST_EMPTY;
                    else r.read_value = close_slot(0);
                MODE_REMOVE_BACK:
                    if (is_empty) r.status = ST_EMPTY;
                    else r.read_value = close_slot(fill - 1);
                MODE_REMOVE_AT:
                    if (is_empty) r.status = ST_EMPTY;
                    else if (p >= fill) r.status = ST_RANGE;
                    else r.read_value = close_slot(p);
                MODE_READ:
                    if (is_empty) r.status = ST_EMPTY;
                    else if (p >= fill) r.status = ST_RANGE;
                    else r.read_value = shadow[p];
                default:
                    if (is_empty) r.status = ST_EMPTY;
                    else if (p >= fill) r.status = ST_RANGE;
                    else shadow[p] = v;
            endcase
            r.count = count_t'(fill);
            expected_q.push_back(r);
        endfunction

        // Called on each accepted response transaction
        task check_result(value_t rv, count_t c, status_t s);
            list_result_t e;
            if (expected_q.size() == 0) begin
                report_mismatch($sformatf("response with none pending: rv=%h cnt=%0d st=%0d",
                                          rv, c, s));
                return;
            end
            e = expected_q.pop_front();
            if (rv !== e.read_value)
                report_mismatch($sformatf("read_value %h, expected %h", rv, e.read_value));
            if (c !== e.count)
                report_mismatch($sformatf("count %0d, expected %0d", c, e.count));
            if (s !== e.status)
                report_mismatch($sformatf("status %0d, expected %0d", s, e.status));
        endtask
    endclass

    logic clk;
    logic rst_n;
    bit steady;
    list_scoreboard sb = new();

    iirl_req_if req_ch ();
    iirl_rsp_if rsp_ch ();

    indexed_insert_remove_list_top DUT (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (req_ch),
        .rsp   (rsp_ch)
    );

    always #(CLK_PERIOD / 2) clk = ~clk;

    // Mostly short gaps, a few long ones, none while running steady
    function automatic int pick_gap();
        int r;
        if (steady)
            return 0;
        r = $urandom_range(0, 99);
        if (r < 55)
            return 0;
        if (r < 90)
            return $urandom_range(1, 3);
        if (r < 97)
            return $urandom_range(4, 10);
        return $urandom_range(11, 40);
    endfunction

    // Drive one request and hold it until the block takes it
    task automatic send_op(mode_t m, pos_t p, value_t v);
        int gap;
        gap = pick_gap();
        if (gap > 0) begin
            req_ch.valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        req_ch.valid    <= 1'b1;
        req_ch.mode     <= m;
        req_ch.position <= p;
        req_ch.value    <= v;
        do
            @(posedge clk);
        while (!req_ch.ready);
        sb.note_request(m, p, v);
    endtask

    // Random operations, biased toward filling or draining the list
    task automatic run_random(int n);
        bit filling;
        int r;
        mode_t m;
        pos_t p;
        value_t v;
        filling = 1'b1;
        for (int k = 0; k < n; k++) begin
            if ($urandom_range(0, 49) == 0)
                steady = ~steady;
            if (filling && sb.fill == DEPTH && $urandom_range(0, 3) == 0)
                filling = 1'b0;
            else if (!filling && sb.fill == 0 && $urandom_range(0, 3) == 0)
                filling = 1'b1;

            r = $urandom_range(0, 99);
            if (r < (filling ? 60 : 20))
                m = mode_t'($urandom_range(MODE_ADD_FRONT, MODE_INSERT_AT));
            else if (r < 80)
                m = mode_t'($urandom_range(MODE_REMOVE_FRONT, MODE_REMOVE_AT));
            else
                m = mode_t'($urandom_range(MODE_READ, MODE_WRITE));

            // Positions mostly legal for the current fill, some anywhere
            if ($urandom_range(0, 9) == 0)
                p = pos_t'($urandom_range(0, 31));
            else if (m == MODE_INSERT_AT)
                p = pos_t'($urandom_range(0, sb.fill));
            else if (sb.fill > 0)
                p = pos_t'($urandom_range(0, sb.fill - 1));
            else
                p = '0;

            r = $urandom_range(0, 19);
            if (r == 0)
                v = '0;
            else if (r == 1)
                v = '1;
            else
                v = $urandom;
            send_op(m, p, v);
        end
    endtask

    // ------------------------------------------------------------------------
    // Response sink: random stalls, held ready while running steady
    // ------------------------------------------------------------------------
    initial begin
        int stall;
        rsp_ch.ready = 1'b0;
        @(posedge rst_n);
        forever begin
            stall = pick_gap();
            if (stall > 0) begin
                rsp_ch.ready <= 1'b0;
                repeat (stall) @(posedge clk);
            end
            rsp_ch.ready <= 1'b1;
            repeat ($urandom_range(1, 6)) @(posedge clk);
        end
    end

    // Response monitor
    always @(posedge clk) begin
        if (rst_n && rsp_ch.valid && rsp_ch.ready)
            sb.check_result(rsp_ch.read_value, rsp_ch.count, rsp_ch.status);
    end

    // Watchdog on cycles with no transaction on either channel
    initial begin
        int idle;
        idle = 0;
        @(posedge rst_n);
        forever begin
            @(posedge clk);
            if ((req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready))
                idle = 0;
            else
                idle++;
            if (idle >= IDLE_LIMIT) begin
                $display("ERROR @%0t: no transaction for %0d cycles", $time, idle);
                $display("SCOREBOARD MISMATCH");
                $finish;
            end
        end
    end

    // ------------------------------------------------------------------------
    // Main sequence
    // ------------------------------------------------------------------------
    initial begin
        clk = 1'b0;
        rst_n = 1'b0;
        steady = 1'b0;
        req_ch.valid = 1'b0;
        req_ch.mode = MODE_ADD_FRONT;
        req_ch.position = '0;
        req_ch.value = '0;
        repeat (RESET_CYCLES) @(posedge clk);
        rst_n <= 1'b1;

        // Everything that can touch an empty list
        send_op(MODE_REMOVE_FRONT, 5'd0, 32'h0);
        send_op(MODE_REMOVE_BACK, 5'd0, 32'h0);
        send_op(MODE_REMOVE_AT, 5'd0, 32'h0);
        send_op(MODE_READ, 5'd0, 32'h0);
        send_op(MODE_WRITE, 5'd0, 32'hDEAD_BEEF);
        send_op(MODE_INSERT_AT, 5'd1, 32'h1111_1111);
        // Build a short list through every insert flavor, append at count too
        send_op(MODE_INSERT_AT, 5'd0, 32'hFFFF_FFFF);
        send_op(MODE_ADD_BACK, 5'd0, 32'h0000_0000);
        send_op(MODE_ADD_FRONT, 5'd0, 32'hA5A5_A5A5);
        send_op(MODE_INSERT_AT, 5'd3, 32'h5A5A_5A5A);
        send_op(MODE_INSERT_AT, 5'd2, 32'h1234_5678);
        // Reads and writes at the ends and just past them
        send_op(MODE_READ, 5'd0, 32'h0);
        send_op(MODE_READ, 5'd4, 32'h0);
        send_op(MODE_READ, 5'd5, 32'h0);
        send_op(MODE_WRITE, 5'd4, 32'hFFFF_0000);
        send_op(MODE_WRITE, 5'd16, 32'h0000_FFFF);
        send_op(MODE_REMOVE_AT, 5'd5, 32'h0);
        send_op(MODE_REMOVE_AT, 5'd31, 32'h0);
        send_op(MODE_INSERT_AT, 5'd16, 32'h7777_7777);
        // Take entries out from the middle and both ends
        send_op(MODE_REMOVE_AT, 5'd2, 32'h0);
        send_op(MODE_REMOVE_BACK, 5'd0, 32'h0);
        send_op(MODE_REMOVE_FRONT, 5'd0, 32'h0);
        send_op(MODE_READ, 5'd1, 32'h0);

        run_random(RANDOM_OPS);
        req_ch.valid <= 1'b0;

        // Drain, then watch for stray responses
        while (sb.pending() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        if (sb.errors == 0 && sb.pending() == 0)
            $display("SCOREBOARD CLEAN");
        else
            $display("SCOREBOARD MISMATCH");
        $finish;
    end

endmodule
